FILE: hdl/ccr_pkg.sv
// shared types, constants and the square root digit step of the circle column rasterizer
`default_nettype none
package ccr_pkg;

   localparam int IN_W             = 12;              // center coordinate width
   localparam int RAD_W            = 10;              // radius width, also root width
   localparam int COL_W            = 11;              // column index width
   localparam int SCR_W            = 12;              // screen size register width
   localparam int CALC_W           = 14;              // signed width of internal coordinates
   localparam int H_W              = RAD_W + 1;       // rounded half height
   localparam int REM_W            = 2 * RAD_W + 1;   // radicand and remainder
   localparam int SQ_W             = 2 * (RAD_W + 1); // square of an offset
   localparam int WIDE_W           = 32;              // widest output coordinate
   localparam int MAX_RADIUS       = 1023;
   localparam int COORD_BITS_DEF   = 13;
   localparam int DIGITS_PER_STAGE = 2;
   localparam int ROOT_STAGES      = RAD_W / DIGITS_PER_STAGE;
   localparam int REQ_TDATA_W      = 48;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd80;
   localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd24;

   typedef enum logic {
      KIND_EDGE = 1'b0,
      KIND_SPAN = 1'b1
   } kind_type;

   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

   // partial root: rem = n - q*q
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [RAD_W-1:0] q;
   } root_type;

   typedef struct packed {
      logic signed [CALC_W-1:0] px;
      logic signed [IN_W-1:0]   cy;
      logic                     has_prev;
   } side_type;

   typedef struct packed {
      root_type cur;
      root_type prev;
      side_type side;
   } root_req_type;

   // one restoring digit of the integer square root at bit k
   function automatic root_type root_step(root_type s, int k);
      logic [REM_W-1:0] trial;
      root_type         o;
      trial = (REM_W'(s.q) << (k + 1)) + (REM_W'(1) << (2 * k));
      o = s;
      if (s.rem >= trial) begin
         o.rem = s.rem - trial;
         o.q   = s.q | (RAD_W'(1) << k);
      end
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/ccr_setup.sv
// front stages: radius clamp, column offsets, squares and radicands
`default_nettype none
module ccr_setup import ccr_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output      logic                    in_ready,
   input  wire logic signed [IN_W-1:0]  center_x,
   input  wire logic signed [IN_W-1:0]  center_y,
   input  wire logic [RAD_W-1:0]        radius,
   input  wire logic [COL_W-1:0]        column_index,
   output      logic                    out_valid,
   input  wire logic                    out_ready,
   output      root_req_type            out_data
);

   localparam int DX_W   = COL_W + 1;
   localparam int DIFF_W = SQ_W + 1;

   logic [RAD_W-1:0]         r_sat;
   logic                     in_range;
   logic signed [DX_W-1:0]   dx;
   logic signed [DX_W-1:0]   dxp;
   logic signed [DX_W-1:0]   dx_neg;
   logic signed [DX_W-1:0]   dxp_neg;
   logic [COL_W-1:0]         adx;
   logic [COL_W-1:0]         adxp;
   logic signed [CALC_W-1:0] px;

   logic                     a_valid_ff;
   logic [RAD_W-1:0]         a_r_ff;
   logic [COL_W-1:0]         a_adx_ff;
   logic [COL_W-1:0]         a_adxp_ff;
   logic signed [CALC_W-1:0] a_px_ff;
   logic signed [IN_W-1:0]   a_cy_ff;
   logic                     a_prev_ff;

   logic [2*RAD_W-1:0]       rr;
   logic [SQ_W-1:0]          sq0;
   logic [SQ_W-1:0]          sq1;
   logic signed [DIFF_W-1:0] d0;
   logic signed [DIFF_W-1:0] d1;
   logic [REM_W-1:0]         n0;
   logic [REM_W-1:0]         n1;

   logic                     b_valid_ff;
   root_req_type             b_data_ff;

   logic                     adv_a;
   logic                     adv_b;

   assign adv_b    = !b_valid_ff || out_ready;
   assign adv_a    = !a_valid_ff || adv_b;
   assign in_ready = adv_a;

   always_comb begin
      r_sat    = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
      in_range = column_index <= {r_sat, 1'b0};
      dx       = $signed({1'b0, column_index}) - $signed({2'b00, r_sat});
      dxp      = dx - DX_W'(1);
      dx_neg   = -dx;
      dxp_neg  = -dxp;
      adx      = dx[DX_W-1]  ? dx_neg[COL_W-1:0]  : dx[COL_W-1:0];
      adxp     = dxp[DX_W-1] ? dxp_neg[COL_W-1:0] : dxp[COL_W-1:0];
      px       = {{(CALC_W-IN_W){center_x[IN_W-1]}}, center_x}
               + {{(CALC_W-DX_W){dx[DX_W-1]}}, dx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         // columns beyond twice the radius are taken and dropped here
         a_valid_ff <= in_valid && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         a_r_ff    <= r_sat;
         a_adx_ff  <= adx;
         a_adxp_ff <= adxp;
         a_px_ff   <= px;
         a_cy_ff   <= center_y;
         a_prev_ff <= column_index != '0;
      end
   end

   always_comb begin
      rr  = a_r_ff * a_r_ff;
      sq0 = a_adx_ff * a_adx_ff;
      sq1 = a_adxp_ff * a_adxp_ff;
      d0  = $signed({3'b000, rr}) - $signed({1'b0, sq0});
      d1  = $signed({3'b000, rr}) - $signed({1'b0, sq1});
      n0  = d0[DIFF_W-1] ? {REM_W{1'b0}} : d0[REM_W-1:0];
      n1  = d1[DIFF_W-1] ? {REM_W{1'b0}} : d1[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b && a_valid_ff) begin
         b_data_ff.cur.rem       <= n0;
         b_data_ff.cur.q         <= '0;
         b_data_ff.prev.rem      <= n1;
         b_data_ff.prev.q        <= '0;
         b_data_ff.side.px       <= a_px_ff;
         b_data_ff.side.cy       <= a_cy_ff;
         b_data_ff.side.has_prev <= a_prev_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule
`default_nettype wire

FILE: hdl/ccr_root.sv
// pipelined integer square root, two lanes, two digits per stage
`default_nettype none
module ccr_root import ccr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire root_req_type  in_data,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      root_req_type  out_data
);

   logic         valid_ff  [ROOT_STAGES];
   root_req_type stage_ff  [ROOT_STAGES];
   root_req_type stage_in  [ROOT_STAGES];
   root_req_type src       [ROOT_STAGES];
   logic         src_valid [ROOT_STAGES];
   logic         adv       [ROOT_STAGES+1];

   assign adv[ROOT_STAGES] = out_ready;

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign src[s]       = in_data;
         assign src_valid[s] = in_valid;
      end else begin : g_body
         assign src[s]       = stage_ff[s-1];
         assign src_valid[s] = valid_ff[s-1];
      end

      assign adv[s] = !valid_ff[s] || adv[s+1];

      always_comb begin : step
         root_req_type tmp;
         tmp = src[s];
         for (int d = 0; d < DIGITS_PER_STAGE; d++) begin
            tmp.cur  = root_step(tmp.cur,  RAD_W - 1 - (DIGITS_PER_STAGE * s + d));
            tmp.prev = root_step(tmp.prev, RAD_W - 1 - (DIGITS_PER_STAGE * s + d));
         end
         stage_in[s] = tmp;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s] && src_valid[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[ROOT_STAGES-1];
   assign out_data  = stage_ff[ROOT_STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/ccr_emit.sv
// rounding, edge and gap span geometry, visibility and the result sequencer
`default_nettype none
module ccr_emit import ccr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [SCR_W-1:0]      screen_width,
   input  wire logic [SCR_W-1:0]      screen_height,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire root_req_type          in_data,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // pixel_x, upper_lo, upper_hi, lower_lo, lower_hi, any_visible, zero fill
   output      logic [((5*COORD_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // kind
   output      logic                  rsp_tuser,
   output      logic                  rsp_tlast
);

   localparam int DATA_W  = 5 * COORD_BITS + 1;
   localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

   function automatic logic [COORD_BITS-1:0] to_coord(logic signed [CALC_W-1:0] v);
      logic [WIDE_W-1:0] w;
      w = {{(WIDE_W-CALC_W){v[CALC_W-1]}}, v};
      return w[COORD_BITS-1:0];
   endfunction

   function automatic logic in_bounds(logic signed [CALC_W-1:0] v, logic [SCR_W-1:0] lim);
      return !v[CALC_W-1] && (v[CALC_W-2:0] < {{(CALC_W-1-SCR_W){1'b0}}, lim});
   endfunction

   // first stage: round to nearest
   logic             e1_valid_ff;
   logic [H_W-1:0]   e1_h_ff;
   logic [H_W-1:0]   e1_hp_ff;
   side_type         e1_side_ff;
   logic [H_W-1:0]   h_rnd;
   logic [H_W-1:0]   hp_rnd;

   // second stage: result hold register
   logic                     hold_valid_ff;
   logic                     hold_valid_in;
   logic                     phase_ff;
   logic                     phase_in;
   logic signed [CALC_W-1:0] px_ff;
   logic signed [CALC_W-1:0] col_ff;
   logic signed [CALC_W-1:0] edge_up_ff;
   logic signed [CALC_W-1:0] edge_dn_ff;
   logic signed [CALC_W-1:0] span_ulo_ff;
   logic signed [CALC_W-1:0] span_uhi_ff;
   logic signed [CALC_W-1:0] span_llo_ff;
   logic signed [CALC_W-1:0] span_lhi_ff;
   logic                     vis_ff;
   logic                     gap_ff;

   logic                     can_load;
   logic                     e1_adv;

   logic signed [CALC_W-1:0] cy;
   logic signed [CALC_W-1:0] hs;
   logic signed [CALC_W-1:0] as;
   logic signed [CALC_W-1:0] bs;
   logic                     prev_lower;
   logic [H_W-1:0]           a_h;
   logic [H_W-1:0]           b_h;
   logic signed [CALC_W-1:0] col;
   logic                     gap;
   logic signed [CALC_W-1:0] edge_up;
   logic signed [CALC_W-1:0] edge_dn;
   logic                     vis;

   logic signed [CALC_W-1:0] out_x;
   logic signed [CALC_W-1:0] out_ulo;
   logic signed [CALC_W-1:0] out_uhi;
   logic signed [CALC_W-1:0] out_llo;
   logic signed [CALC_W-1:0] out_lhi;
   logic                     out_vis;
   logic [DATA_W-1:0]        out_data;
   kind_type                 out_kind;

   // the hold register frees once its last transaction is taken
   assign can_load = !hold_valid_ff || (rsp_tready && (phase_ff || !gap_ff));
   assign e1_adv   = !e1_valid_ff || can_load;
   assign in_ready = e1_adv;

   always_comb begin
      h_rnd  = H_W'(in_data.cur.q)  + H_W'(in_data.cur.rem  > REM_W'(in_data.cur.q));
      hp_rnd = H_W'(in_data.prev.q) + H_W'(in_data.prev.rem > REM_W'(in_data.prev.q));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (e1_adv) begin
         e1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e1_adv && in_valid) begin
         e1_h_ff    <= h_rnd;
         e1_hp_ff   <= hp_rnd;
         e1_side_ff <= in_data.side;
      end
   end

   always_comb begin
      cy         = {{(CALC_W-IN_W){e1_side_ff.cy[IN_W-1]}}, e1_side_ff.cy};
      prev_lower = e1_hp_ff < e1_h_ff;
      a_h        = prev_lower ? e1_hp_ff : e1_h_ff;
      b_h        = prev_lower ? e1_h_ff  : e1_hp_ff;
      hs         = $signed({{(CALC_W-H_W){1'b0}}, e1_h_ff});
      as         = $signed({{(CALC_W-H_W){1'b0}}, a_h});
      bs         = $signed({{(CALC_W-H_W){1'b0}}, b_h});
      // span sits on whichever column has the lower height
      col        = prev_lower ? e1_side_ff.px - CALC_W'(1) : e1_side_ff.px;
      gap        = e1_side_ff.has_prev && ((b_h - a_h) > H_W'(1));
      edge_up    = cy + hs;
      edge_dn    = cy - hs;
      vis        = (in_bounds(e1_side_ff.px, screen_width) && in_bounds(edge_up, screen_height))
                || (in_bounds(e1_side_ff.px, screen_width) && in_bounds(edge_dn, screen_height));
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      phase_in      = phase_ff;
      if (can_load) begin
         hold_valid_in = e1_valid_ff;
         phase_in      = 1'b0;
      end else if (rsp_tready) begin
         // edge taken, span still to go
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && e1_valid_ff) begin
         px_ff       <= e1_side_ff.px;
         col_ff      <= col;
         edge_up_ff  <= edge_up;
         edge_dn_ff  <= edge_dn;
         span_ulo_ff <= cy + as + CALC_W'(1);
         span_uhi_ff <= cy + bs - CALC_W'(1);
         span_llo_ff <= cy - bs + CALC_W'(1);
         span_lhi_ff <= cy - as - CALC_W'(1);
         vis_ff      <= vis;
         gap_ff      <= gap;
      end
   end

   always_comb begin
      out_x    = phase_ff ? col_ff      : px_ff;
      out_ulo  = phase_ff ? span_ulo_ff : edge_up_ff;
      out_uhi  = phase_ff ? span_uhi_ff : edge_up_ff;
      out_llo  = phase_ff ? span_llo_ff : edge_dn_ff;
      out_lhi  = phase_ff ? span_lhi_ff : edge_dn_ff;
      out_vis  = !phase_ff && vis_ff;
      out_kind = phase_ff ? KIND_SPAN : KIND_EDGE;
      out_data = {out_vis, to_coord(out_lhi), to_coord(out_llo), to_coord(out_uhi),
                  to_coord(out_ulo), to_coord(out_x)};
   end

   assign rsp_tvalid = hold_valid_ff;
   assign rsp_tdata  = TDATA_W'(out_data);
   assign rsp_tuser  = out_kind;
   assign rsp_tlast  = phase_ff || !gap_ff;

endmodule
`default_nettype wire

FILE: hdl/circle_column_rasterizer.sv
// top level: register port, stream ports and the setup, root and emit pipeline
//
// Circle column rasterizer. Each req transaction carries a circle center, a radius and a
// column index i in 0..2r; the block answers with an edge transaction (the pixel pair at
// column cx+i-r, rows cy+h and cy-h, h the rounded half height) and, where the height
// jumps by more than one from the previous column, a gap span transaction right after it,
// marked with tuser = 1. tlast flags the final transaction of each column. Columns with
// i > 2r are taken and produce nothing. A new column is accepted every cycle unless a
// held result stalls the pipeline, as a span or a low rsp_tready does; results leave
// at one transaction per cycle, the single result port being the limit. From req to the
// first rsp transaction a column passes two setup stages (offsets, then squares), five
// square root stages of two root bits each, a rounding stage and the output register.
// screen_width (address 0x0) and screen_height (address 0x4) set the visibility test and
// may only be written while the pipeline is empty.
`default_nettype none
module circle_column_rasterizer import ccr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   // center_x, center_y, radius, column_index, zero fill
   input  wire logic [REQ_TDATA_W-1:0]       req_tdata,
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   // pixel_x, upper_lo, upper_hi, lower_lo, lower_hi, any_visible, zero fill
   output      logic [((5*COORD_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // kind
   output      logic                         rsp_tuser,
   output      logic                         rsp_tlast,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]        csr_pwdata,
   output      logic [CSR_DATA_W-1:0]        csr_prdata,
   output      logic                         csr_pready
);

   localparam int VIS_BIT = 5 * COORD_BITS;

   logic [SCR_W-1:0]       screen_width_ff;
   logic [SCR_W-1:0]       screen_height_ff;
   logic                   csr_write;
   reg_index_type          reg_sel;

   logic signed [IN_W-1:0] center_x;
   logic signed [IN_W-1:0] center_y;
   logic [RAD_W-1:0]       radius;
   logic [COL_W-1:0]       column_index;

   logic                   setup_valid;
   logic                   root_ready;
   root_req_type           setup_data;
   logic                   root_valid;
   logic                   emit_ready;
   root_req_type           root_data;

   // register port, byte addressed, one register per word
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
      end else if (csr_write) begin
         case (reg_sel)
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_pwdata[SCR_W-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[SCR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_W'(screen_width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_W'(screen_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign center_x     = req_tdata[IN_W-1:0];
   assign center_y     = req_tdata[2*IN_W-1:IN_W];
   assign radius       = req_tdata[2*IN_W+RAD_W-1:2*IN_W];
   assign column_index = req_tdata[2*IN_W+RAD_W+COL_W-1:2*IN_W+RAD_W];

   ccr_setup u_setup (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .center_x     (center_x),
      .center_y     (center_y),
      .radius       (radius),
      .column_index (column_index),
      .out_valid    (setup_valid),
      .out_ready    (root_ready),
      .out_data     (setup_data)
   );

   ccr_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_ready  (root_ready),
      .in_data   (setup_data),
      .out_valid (root_valid),
      .out_ready (emit_ready),
      .out_data  (root_data)
   );

   ccr_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .in_valid      (root_valid),
      .in_ready      (emit_ready),
      .in_data       (root_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

   // an edge that is not last must be followed by its span
   a_span_follows_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_EDGE && !rsp_tlast
      |=> rsp_tvalid && rsp_tuser == KIND_SPAN)
      else $error("gap span missing after its edge transaction");

   a_span_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SPAN |-> rsp_tlast && !rsp_tdata[VIS_BIT])
      else $error("span transaction not last or flagged visible");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule
`default_nettype wire

FILE: tb/circle_column_rasterizer_checker.sv
`timescale 1ns / 100ps
// channel monitor for the circle column rasterizer: predicts column transactions and compares
module circle_column_rasterizer_checker import ccr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   input  wire logic                                    req_tready,
   // center_x, center_y, radius, column_index, zero fill
   input  wire logic [REQ_TDATA_W-1:0]                  req_tdata,
   input  wire logic                                    rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // pixel_x, upper_lo, upper_hi, lower_lo, lower_hi, any_visible, zero fill
   input  wire logic [((5*COORD_BITS+1+7)/8)*8-1:0]     rsp_tdata,
   // kind
   input  wire logic                                    rsp_tuser,
   input  wire logic                                    rsp_tlast,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]                   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]                   csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0]                   csr_prdata,
   input  wire logic                                    csr_pready,
   output int                                           mismatch_count,
   output int                                           pending_results
);

   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = CSR_ADDR_W'(4 * int'(REG_SCREEN_WIDTH));
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = CSR_ADDR_W'(4 * int'(REG_SCREEN_HEIGHT));

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      kind_type  kind;
      coord_type pixel_x;
      coord_type upper_lo;
      coord_type upper_hi;
      coord_type lower_lo;
      coord_type lower_hi;
      logic      any_visible;
      logic      last;
   } pixel_result_type;

   pixel_result_type expected_pixels[$];
   logic [SCR_W-1:0] surface_width;
   logic [SCR_W-1:0] surface_height;

   // exact floor root, then round up when n - s*s exceeds s
   function automatic longint rounded_root(longint n);
      longint s;
      longint t;
      int     b;
      s = 0;
      for (b = RAD_W; b >= 0; b--) begin
         t = s + (longint'(1) << b);
         if (t * t <= n) s = t;
      end
      if (n - s * s > s) s = s + 1;
      return s;
   endfunction

   function automatic longint half_rows(longint r, longint dx);
      longint n;
      n = r * r - dx * dx;
      if (n < 0) n = 0;
      return rounded_root(n);
   endfunction

   function automatic logic on_surface(longint x, longint y);
      return x >= 0 && x < longint'(surface_width) && y >= 0 && y < longint'(surface_height);
   endfunction

   task automatic predict_column(input logic [REQ_TDATA_W-1:0] d);
      longint           cx, cy, r, i, dx, h, hp, px, a, b, col;
      logic             gap;
      pixel_result_type e;
      cx = longint'($signed(d[IN_W-1:0]));
      cy = longint'($signed(d[2*IN_W-1:IN_W]));
      r  = longint'(d[2*IN_W +: RAD_W]);
      i  = longint'(d[2*IN_W+RAD_W +: COL_W]);
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      if (i > 2 * r) return;
      dx  = i - r;
      h   = half_rows(r, dx);
      px  = cx + dx;
      gap = 1'b0;
      a   = 0;
      b   = 0;
      col = 0;
      if (i > 0) begin
         hp = half_rows(r, dx - 1);
         // the span sits on whichever column is lower
         if (hp < h) begin
            a   = hp;
            b   = h;
            col = px - 1;
         end else begin
            a   = h;
            b   = hp;
            col = px;
         end
         gap = (b - a) > 1;
      end
      e.kind        = KIND_EDGE;
      e.pixel_x     = coord_type'(px);
      e.upper_lo    = coord_type'(cy + h);
      e.upper_hi    = coord_type'(cy + h);
      e.lower_lo    = coord_type'(cy - h);
      e.lower_hi    = coord_type'(cy - h);
      e.any_visible = on_surface(px, cy + h) || on_surface(px, cy - h);
      e.last        = !gap;
      expected_pixels.push_back(e);
      if (gap) begin
         e.kind        = KIND_SPAN;
         e.pixel_x     = coord_type'(col);
         e.upper_lo    = coord_type'(cy + a + 1);
         e.upper_hi    = coord_type'(cy + b - 1);
         e.lower_lo    = coord_type'(cy - b + 1);
         e.lower_hi    = coord_type'(cy - a - 1);
         e.any_visible = 1'b0;
         e.last        = 1'b1;
         expected_pixels.push_back(e);
      end
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      pixel_result_type e;
      if (reset) begin
         expected_pixels.delete();
         surface_width  = SCREEN_WIDTH_RST;
         surface_height = SCREEN_HEIGHT_RST;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr)
                  WIDTH_ADDR:  surface_width  = csr_pwdata[SCR_W-1:0];
                  HEIGHT_ADDR: surface_height = csr_pwdata[SCR_W-1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr)
                  WIDTH_ADDR:  check_field("screen_width read", surface_width, csr_prdata);
                  HEIGHT_ADDR: check_field("screen_height read", surface_height, csr_prdata);
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) predict_column(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t unexpected result transaction 0x%0h", $time, rsp_tdata);
            end else begin
               e = expected_pixels.pop_front();
               check_field("kind", e.kind, rsp_tuser);
               check_field("pixel_x", e.pixel_x, rsp_tdata[0 +: COORD_BITS]);
               check_field("upper_lo", e.upper_lo, rsp_tdata[COORD_BITS +: COORD_BITS]);
               check_field("upper_hi", e.upper_hi, rsp_tdata[2*COORD_BITS +: COORD_BITS]);
               check_field("lower_lo", e.lower_lo, rsp_tdata[3*COORD_BITS +: COORD_BITS]);
               check_field("lower_hi", e.lower_hi, rsp_tdata[4*COORD_BITS +: COORD_BITS]);
               check_field("any_visible", e.any_visible, rsp_tdata[5*COORD_BITS]);
               check_field("last", e.last, rsp_tlast);
            end
         end
      end
      pending_results = expected_pixels.size();
   end

endmodule

FILE: tb/circle_column_rasterizer_tb.sv
`timescale 1ns / 100ps
// top of the circle column rasterizer testbench: clock, reset, stimulus and verdict
module circle_column_rasterizer_tb;
   import ccr_pkg::*;

   localparam int RSP_TDATA_W   = ((5*COORD_BITS_DEF+1+7)/8)*8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_COLUMNS = 210;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_MOSTLY,
      RX_COMB
   } rx_pattern_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int mismatch_count;
   int pending_results;
   int cycle_count   = 0;
   int columns_sent  = 0;
   int burst_left    = 0;
   int hold_requests = 0;

   rx_pattern_type rx_pattern = RX_OPEN;
   int             rx_left    = 0;
   int             rx_phase   = 0;
   int             hold_left  = 0;
   int             hold_seen  = 0;

   circle_column_rasterizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   circle_column_rasterizer_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[circle_column_rasterizer] ERROR");
         $finish;
      end
   end

   // result side backpressure, with a long hold-off whenever one is requested
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            rx_left    = $urandom_range(20, 300);
         end
         rx_left--;
         rx_phase++;
         case (rx_pattern)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:   rsp_tready <= (rx_phase % 5) >= 2;
         endcase
      end
   end

   task automatic send_column(input logic signed [IN_W-1:0] cx, input logic signed [IN_W-1:0] cy,
                              input logic [RAD_W-1:0] r, input logic [COL_W-1:0] i);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_tdata  = REQ_TDATA_W'({i, r, cy, cx});
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      if (i <= 2 * r) columns_sent++;
   endtask

   task automatic csr_access(input logic write, input reg_index_type idx,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_surface(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      csr_access(1'b1, REG_SCREEN_WIDTH, w);
      csr_access(1'b1, REG_SCREEN_HEIGHT, h);
      csr_access(1'b0, REG_SCREEN_WIDTH, '0);
      csr_access(1'b0, REG_SCREEN_HEIGHT, '0);
   endtask

   // wait for every predicted result, then let the pipeline settle with no request driven
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_traffic(input int target);
      int                     goal, pick, size_roll, first_col, last_col, c;
      logic signed [IN_W-1:0] cx, cy;
      logic [RAD_W-1:0]       r;
      goal = columns_sent + target;
      while (columns_sent < goal) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 1) == 0) begin
            cx = IN_W'($urandom);
            cy = IN_W'($urandom);
         end else begin
            cx = IN_W'($urandom_range(0, 260) - 30);
            cy = IN_W'($urandom_range(0, 180) - 30);
         end
         size_roll = $urandom_range(0, 19);
         if (size_roll < 14) r = RAD_W'($urandom_range(0, 20));
         else if (size_roll < 19) r = RAD_W'($urandom_range(21, 120));
         else r = RAD_W'($urandom_range(121, MAX_RADIUS));
         if (pick < 70) begin
            // consecutive columns of one circle, big circles cut to a window
            first_col = 0;
            last_col  = 2 * r;
            if (last_col > 63) begin
               case ($urandom_range(0, 2))
                  0: last_col = 63;
                  1: first_col = last_col - 63;
                  default: begin
                     first_col = $urandom_range(0, last_col - 63);
                     last_col  = first_col + 63;
                  end
               endcase
            end
            for (c = first_col; c <= last_col; c++) send_column(cx, cy, r, COL_W'(c));
         end else if (pick < 85) begin
            send_column(cx, cy, RAD_W'($urandom_range(0, MAX_RADIUS)),
                        COL_W'($urandom_range(0, 2047)));
         end else begin
            // scattered columns, some beyond the circle
            repeat ($urandom_range(1, 8))
               send_column(cx, cy, r, COL_W'($urandom_range(0, 2 * r + 4)));
         end
      end
   endtask

   initial begin : stimulus
      int unsigned surface_w[6];
      int unsigned surface_h[6];
      int          p;
      surface_w = '{0, 4095, 1, 0, 160, 200};
      surface_h = '{0, 4095, 1, 0, 0, 120};
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // single point and a column past a zero radius
      send_column(0, 0, 0, 0);
      send_column(0, 0, 0, 1);
      // small circle on the default surface: ends, center, neighbor, overrun
      send_column(10, 10, 5, 0);
      send_column(10, 10, 5, 1);
      send_column(10, 10, 5, 5);
      send_column(10, 10, 5, 6);
      send_column(10, 10, 5, 10);
      send_column(10, 10, 5, 11);
      // upper edge pixel off screen and lower on, then the reverse
      send_column(40, 20, 10, 10);
      send_column(40, -5, 10, 10);
      // widest circle at the coordinate extremes
      send_column(-2048, -2048, 1023, 0);
      send_column(-2048, -2048, 1023, 1);
      send_column(2047, 2047, 1023, 2046);
      send_column(2047, 2047, 1023, 2047);
      send_column(0, 12, 1023, 1023);
      send_column(2047, -2048, 1023, 1024);
      send_column(-1, -1, 1023, 2045);
      // surface corners
      send_column(79, 23, 0, 0);
      send_column(80, 0, 0, 0);
      send_column(0, 24, 0, 0);
      send_column(-1, 0, 1, 1);
      drain();

      csr_access(1'b0, REG_SCREEN_WIDTH, '0);
      csr_access(1'b0, REG_SCREEN_HEIGHT, '0);
      random_traffic(PHASE_COLUMNS);
      drain();

      for (p = 0; p < 6; p++) begin
         if (p == 3) set_surface($urandom, $urandom);
         else set_surface(surface_w[p], surface_h[p]);
         if (p == 4) hold_requests++;
         random_traffic(PHASE_COLUMNS);
         drain();
      end

      if (mismatch_count == 0 && pending_results == 0)
         $display("[circle_column_rasterizer] OK");
      else
         $display("[circle_column_rasterizer] ERROR");
      $finish;
   end

endmodule
